// File: rtl/rkx_pkg.sv
package rkx_pkg;

    // field widths of the stream items and the key length register
    localparam int unsigned KEY_LEN_W  = 11;
    localparam int unsigned KEY_ADDR_W = 10;
    localparam int unsigned BYTE_W     = 8;

    // slave tdata: key_address, value, zero padding up to whole bytes
    localparam int unsigned S_TDATA_W  = 24;

    // default key store depth
    localparam int unsigned KEY_DEPTH_DEF = 1024;

    // result queue between ram output and master side
    localparam int unsigned FIFO_DEPTH = 3;
    localparam int unsigned PTR_W      = 2;

    // request kind carried in tuser
    typedef enum logic {
        MODE_KEY_WRITE = 1'b0,
        MODE_ENCODE    = 1'b1
    } mode_t;

endpackage

// File: rtl/rotating_key_xor_cipher_unit.sv
// Rotating-key XOR cipher unit.
// Requests enter on the s_ channel: tuser selects a key write or an encode,
// tdata carries the key address and the byte. A key write stores the byte at
// the address (addresses at or beyond KEY_DEPTH are dropped) and restarts the
// key stream at round zero; it gives no result. An encode returns the byte
// XORed with the current key stream byte on the m_ channel. Encoding and
// decoding are the same operation.
// The key length is written through cfg_we / cfg_wdata; the user must do so
// only while the unit is idle, as the unit itself does not enforce it; zero is
// taken as one and values above KEY_DEPTH as KEY_DEPTH. Throughput: one request
// per cycle while s_tready is high. A result passes the registered read of the
// key ram and then the result queue on its way to the m_ channel.
// A three-entry result queue absorbs the ram output, so when the receiver
// stalls, requests keep being taken until the ram stage and the queue hold
// three results between them, then s_tready drops; no result is lost.
// Reset clears the stream position, the queue and sets the key length to one.
// Key ram contents are not cleared and need no clearing pass.
module rotating_key_xor_cipher_unit #(
    parameter int unsigned KEY_DEPTH = rkx_pkg::KEY_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rkx_pkg::KEY_LEN_W-1:0]  cfg_wdata,   // key_length
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rkx_pkg::S_TDATA_W-1:0]  s_tdata,     // key_address[9:0], value[17:10]
    input  logic [0:0]                     s_tuser,     // mode[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rkx_pkg::BYTE_W-1:0]     m_tdata      // data_out[7:0]
);

    import rkx_pkg::*;

    localparam int unsigned AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int unsigned LEN_W = $clog2(KEY_DEPTH + 1);
    localparam int unsigned CW    = AW + 1;

    // request fields
    mode_t                 in_mode;
    logic [KEY_ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0]     in_value;
    logic                  in_accept;
    logic                  in_encode;
    logic                  in_key_write;

    assign in_mode      = mode_t'(s_tuser[0]);
    assign in_addr      = s_tdata[KEY_ADDR_W-1:0];
    assign in_value     = s_tdata[KEY_ADDR_W +: BYTE_W];
    assign in_accept    = s_tvalid && s_tready;
    assign in_encode    = in_accept && (in_mode == MODE_ENCODE);
    assign in_key_write = in_accept && (in_mode == MODE_KEY_WRITE);

    // effective key length register
    logic [LEN_W-1:0] eff_len_reg;
    logic [LEN_W-1:0] eff_len_next;
    logic [31:0]      cfg_len_ext;

    always_comb begin
        cfg_len_ext  = 32'(cfg_wdata);
        eff_len_next = eff_len_reg;
        if (cfg_we) begin
            if (cfg_len_ext == 32'd0) begin
                eff_len_next = LEN_W'(1);
            end else if (cfg_len_ext > 32'(KEY_DEPTH)) begin
                eff_len_next = LEN_W'(KEY_DEPTH);
            end else begin
                eff_len_next = LEN_W'(cfg_len_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_len_reg <= LEN_W'(1);
        end else begin
            eff_len_reg <= eff_len_next;
        end
    end

    // key stream position: round start, position in round, key index
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_inc, start_inc, idx_inc, len_ext;

    always_comb begin
        pos_inc    = CW'(pos_reg) + CW'(1);
        start_inc  = CW'(start_reg) + CW'(1);
        idx_inc    = CW'(idx_reg) + CW'(1);
        len_ext    = CW'(eff_len_reg);
        pos_next   = pos_reg;
        start_next = start_reg;
        idx_next   = idx_reg;
        if (in_key_write) begin
            pos_next   = '0;
            start_next = '0;
            idx_next   = '0;
        end else if (in_encode) begin
            if (pos_inc >= len_ext) begin
                // end of round: next round starts one key byte further on
                start_next = (start_inc >= len_ext) ? '0 : start_inc[AW-1:0];
                pos_next   = '0;
                idx_next   = start_next;
            end else begin
                pos_next = pos_inc[AW-1:0];
                idx_next = (idx_inc >= len_ext) ? '0 : idx_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            idx_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            idx_reg   <= idx_next;
        end
    end

    // key ram: written by key writes, read at the current key index
    logic [31:0]       waddr_ext;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign waddr_ext = 32'(in_addr);
    assign ram_we    = in_key_write && (waddr_ext < 32'(KEY_DEPTH));
    assign ram_waddr = waddr_ext[AW-1:0];

    rkx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ram read stage: the data byte waits for its key byte
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_encode;
        end
    end

    always_ff @(posedge aclk) begin
        s1_value_reg <= in_value;
    end

    // result queue
    logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg, cnt_reg;
    logic [PTR_W-1:0]  wr_ptr_next, rd_ptr_next, cnt_next;
    logic [PTR_W:0]    occupancy;
    logic              pop;

    assign pop       = m_tvalid && m_tready;
    assign occupancy = (PTR_W + 1)'(cnt_reg) + (PTR_W + 1)'(s1_valid_reg);
    assign s_tready  = occupancy < (PTR_W + 1)'(FIFO_DEPTH);
    assign m_tvalid  = cnt_reg != '0;
    assign m_tdata   = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (s1_valid_reg) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + PTR_W'(s1_valid_reg) - PTR_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= s1_value_reg ^ ram_rdata;
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (PTR_W + 1)'(FIFO_DEPTH))
        else $error("result queue overrun");

    a_key_write_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        in_key_write |=> (pos_reg == '0) && (start_reg == '0) && (idx_reg == '0))
        else $error("key write did not restart the stream");

    a_encode_to_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        in_encode |=> s1_valid_reg)
        else $error("encode request lost before ram stage");

    a_stage_to_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> (cnt_reg != '0))
        else $error("ram stage result not queued");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW'(idx_reg) < CW'(KEY_DEPTH)) && (CW'(start_reg) < CW'(KEY_DEPTH)))
        else $error("key index beyond key store");

endmodule

// File: rtl/rkx_ram.sv
module rkx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: dv/tb_rotating_key_xor_cipher_unit.sv
`timescale 1ns / 1ps

module tb_rotating_key_xor_cipher_unit;
    import rkx_pkg::*;

    localparam int DEPTH        = KEY_DEPTH_DEF;
    localparam int SETTLE       = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PAD_W        = S_TDATA_W - KEY_ADDR_W - BYTE_W;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [KEY_LEN_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // key_address[9:0], value[17:10]
    logic [0:0]           s_tuser   = 1'b0;  // mode[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;           // data_out[7:0]

    // shadow of the key ram and the stream position
    logic [BYTE_W-1:0]    key_mem [DEPTH];
    bit                   key_known [DEPTH];
    logic [KEY_LEN_W-1:0] key_len_reg = KEY_LEN_W'(1);
    int                   round_pos   = 0;
    int                   round_base  = 0;
    int                   stream_idx  = 0;
    logic [BYTE_W-1:0]    expected_bytes [$];

    int fail_count   = 0;
    int n_key_writes = 0;
    int n_encodes    = 0;
    int n_checked    = 0;
    int n_len_writes = 0;
    int burst_left   = 0;
    int cycle_count  = 0;
    int rx_cycle     = 0;
    int rx_style     = 0;
    int rx_hold      = 0;

    rotating_key_xor_cipher_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver back-pressure, in a randomly chosen style that changes over the run
    always @(posedge aclk) begin
        if (rx_cycle % 300 == 0)
            rx_style = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 5) != 0;
            default: begin
                if (rx_hold != 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        rx_hold = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // compare each result with the oldest outstanding byte
    always @(posedge aclk) begin : result_check
        logic [BYTE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%02h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                n_checked++;
                if (m_tdata !== want) begin
                    $display("%0t: data_out mismatch, expected 0x%02h, actual 0x%02h",
                             $time, want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    function automatic int eff_len();
        if (key_len_reg == 0)
            return 1;
        if (key_len_reg > DEPTH)
            return DEPTH;
        return int'(key_len_reg);
    endfunction

    // advance the shadow cipher by one accepted request
    function automatic void cipher_step(input mode_t mode,
                                        input logic [KEY_ADDR_W-1:0] addr,
                                        input logic [BYTE_W-1:0] val);
        int len;
        int nxt;
        len = eff_len();
        if (mode == MODE_KEY_WRITE) begin
            key_mem[addr]   = val;
            key_known[addr] = 1'b1;
            round_pos  = 0;
            round_base = 0;
            stream_idx = 0;
            n_key_writes++;
        end else begin
            expected_bytes.push_back(val ^ key_mem[stream_idx]);
            n_encodes++;
            nxt = round_pos + 1;
            if (nxt >= len) begin
                // next round starts one key byte further on
                round_base = (round_base + 1 >= len) ? 0 : round_base + 1;
                round_pos  = 0;
                stream_idx = round_base;
            end else begin
                round_pos  = nxt;
                stream_idx = (stream_idx + 1 >= len) ? 0 : stream_idx + 1;
            end
        end
    endfunction

    // one request, with a random gap between bursts
    task automatic send_request(input mode_t mode,
                                input logic [KEY_ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{PAD_W{1'b0}}, val, addr};
        do @(posedge aclk); while (!s_tready);
        cipher_step(mode, addr, val);
        burst_left--;
    endtask

    task automatic key_write(input int addr, input int val);
        send_request(MODE_KEY_WRITE, KEY_ADDR_W'(addr), BYTE_W'(val));
    endtask

    // never let the stream read a key byte that has not been written
    task automatic send_data(input int val);
        while (!key_known[stream_idx])
            key_write(stream_idx, $urandom);
        send_request(MODE_ENCODE, KEY_ADDR_W'($urandom), BYTE_W'(val));
    endtask

    task automatic key_fill(input int len);
        for (int a = 0; a < len; a++)
            key_write(a, $urandom);
    endtask

    // hold off until all results are back and the pipeline is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_key_length(input int len);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= KEY_LEN_W'(len);
        @(posedge aclk);
        key_len_reg = KEY_LEN_W'(len);
        cfg_we <= 1'b0;
        n_len_writes++;
    endtask

    // reset length of one, extreme addresses and byte values
    task automatic test_reset_length();
        key_write(DEPTH - 1, 8'hFF);
        key_write(0, 8'h00);
        send_data(8'h00);
        send_data(8'hFF);
        key_write(0, 8'hC3);
    endtask

    // rounds start one key byte later, a key write restarts round zero
    task automatic test_round_rotation();
        write_key_length(3);
        key_write(0, 8'h11);
        key_write(1, 8'h22);
        key_write(2, 8'h44);
        for (int i = 0; i < 6; i++)
            send_data($urandom);
        key_write(1, 8'h88);
        send_data(8'h00);
        send_data(8'hFF);
    endtask

    // length zero behaves as one
    task automatic test_length_zero();
        write_key_length(0);
        send_data(8'hA5);
        send_data(8'h5A);
    endtask

    // shrink the length while the key index sits beyond the new length
    task automatic test_length_shrink();
        write_key_length(5);
        key_write(3, 8'h0F);
        key_write(4, 8'hF0);
        for (int i = 0; i < 4; i++)
            send_data($urandom);
        write_key_length(2);
        for (int i = 0; i < 3; i++)
            send_data($urandom);
    endtask

    // full key depth, and lengths above the depth saturating to it
    task automatic test_full_depth();
        key_fill(48);
        write_key_length(DEPTH);
        for (int i = 0; i < 40; i++)
            send_data($urandom);
        write_key_length(2047);
        for (int i = 0; i < 40; i++)
            send_data($urandom);
        write_key_length(DEPTH + 1);
        for (int i = 0; i < 40; i++)
            send_data($urandom);
    endtask

    // phases of random length, optional fresh key, stream with some noise
    task automatic test_random_traffic();
        int sent;
        int pick;
        int len;
        int eff;
        int count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = 0;
            else if (pick == 1)
                len = DEPTH;
            else if (pick == 2)
                len = $urandom_range(DEPTH + 1, 2047);
            else if (pick <= 5)
                len = $urandom_range(17, 200);
            else
                len = $urandom_range(1, 16);
            write_key_length(len);
            eff = eff_len();
            if (eff <= 64 && $urandom_range(0, 1) == 1) begin
                key_fill(eff);
                sent += eff;
            end
            if (eff <= 200 && $urandom_range(0, 3) == 0)
                count = $urandom_range(eff, 2 * eff + 5);
            else
                count = $urandom_range(5, 80);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 24) == 0)
                    key_write($urandom_range(0, DEPTH - 1), $urandom);
                else if ($urandom_range(0, 49) == 0)
                    wait_idle();
                else
                    send_data($urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_length();
        test_round_rotation();
        test_length_zero();
        test_length_shrink();
        test_full_depth();
        test_random_traffic();

        wait_idle();
        $display("run covered %0d key writes and %0d encodes, %0d results checked",
                 n_key_writes, n_encodes, n_checked);
        $display("key length set %0d times: zero, one, full depth, above depth, shrinks",
                 n_len_writes);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
